>>> rtl/core/hyperplane_embedding_score_rank_top_defines.svh
// Assertion macros shared by the scorer's RTL files.
`ifndef HYPERPLANE_EMBEDDING_SCORE_RANK_TOP_DEFINES_SVH
`define HYPERPLANE_EMBEDDING_SCORE_RANK_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define HESR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define HESR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hesr_pkg.sv
// Shared types, widths and the tuple-end step table of the scorer.
package hesr_pkg;

  localparam int ITEM_W         = 12;
  localparam int OPND_W         = 29;
  localparam int PROD_W         = 58;
  localparam int WSUM_W         = 27;
  localparam int VSUM_W         = 28;
  localparam int SQ_W           = 58;
  localparam int NDOT_W         = 45;
  localparam int NEN_W          = 31;
  localparam int SCORE_W        = 48;
  localparam int RANK_W         = 17;
  localparam int ACC_W          = 128;
  localparam int LIMB_W         = 28;
  localparam int MAG_W          = NDOT_W;
  localparam int P_W            = 2 * MAG_W - 1;
  localparam int SHIFT_W        = 7;
  localparam int STEP_W         = 5;
  localparam int TMAC_LAST      = 18;
  localparam int BIAS_SHIFT     = 10;
  localparam int Q_SHIFT        = 40;
  localparam int CROSS_SHIFT    = 21;
  localparam int SCORE_LSB      = 64;
  localparam int MAX_CANDIDATES = 65535;

  localparam logic [RANK_W-1:0]  RANK_ONE  = RANK_W'(1);
  localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(MAX_CANDIDATES + 1);
  localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

  // Where a product from the shared multiplier is accumulated.
  typedef enum logic [2:0] {
    DST_NONE,
    DST_WSUM,
    DST_SQ,
    DST_NDOT,
    DST_NCROSS,
    DST_NENERGY,
    DST_ACC,
    DST_ACC_CROSS
  } dest_t;

  typedef enum logic [3:0] {
    A_ENTITY,
    A_NORMAL,
    A_VSUM,
    A_S0,
    A_S1,
    A_P0,
    A_P1,
    A_P2,
    A_P3
  } asel_t;

  typedef enum logic [3:0] {
    B_WEIGHT,
    B_NORMAL,
    B_WSUM,
    B_VSUM,
    B_S0,
    B_S1,
    B_K0,
    B_K1,
    B_E0,
    B_E1
  } bsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AX,
    S_NN,
    S_NW,
    S_VV,
    S_NV,
    S_TDRAIN,
    S_TMAG,
    S_TMAC,
    S_FIN
  } state_t;

  typedef struct packed {
    dest_t               dest;
    asel_t               a_sel;
    bsel_t               b_sel;
    logic [SHIFT_W-1:0]  shift;
  } issue_t;

  typedef struct packed {
    dest_t               dest;
    logic [SHIFT_W-1:0]  shift;
  } tag_t;

  typedef struct packed {
    issue_t  issue;
    logic    latch_p;
  } step_t;

  typedef struct packed {
    logic    capture;
    issue_t  issue;
    logic    load_v;
    logic    clear_wsum;
    logic    load_mag;
    logic    latch_p;
    logic    finish;
  } ctrl_t;

  function automatic issue_t mac(input dest_t dest, input asel_t a_sel,
                                 input bsel_t b_sel, input int shift);
    issue_t r;
    r.dest  = dest;
    r.a_sel = a_sel;
    r.b_sel = b_sel;
    r.shift = SHIFT_W'(shift);
    return r;
  endfunction

  // Tuple-end schedule: s*s into the accumulator, then the product is
  // latched and the accumulator restarts from Q, takes (s*s)*E limb by
  // limb and finally the signed cross term. Products land in the cycle after issue.
  function automatic step_t tuple_step(input logic [STEP_W-1:0] idx);
    step_t s;
    s.issue   = mac(DST_NONE, A_S0, B_S0, 0);
    s.latch_p = 1'b0;
    case (idx)
      STEP_W'(0):  s.issue = mac(DST_ACC, A_S0, B_S0, 0);
      STEP_W'(1):  s.issue = mac(DST_ACC, A_S0, B_S1, LIMB_W);
      STEP_W'(2):  s.issue = mac(DST_ACC, A_S1, B_S0, LIMB_W);
      STEP_W'(3):  s.issue = mac(DST_ACC, A_S1, B_S1, 2 * LIMB_W);
      STEP_W'(5):  s.latch_p = 1'b1;
      STEP_W'(6):  s.issue = mac(DST_ACC, A_P0, B_E0, 0);
      STEP_W'(7):  s.issue = mac(DST_ACC, A_P1, B_E0, LIMB_W);
      STEP_W'(8):  s.issue = mac(DST_ACC, A_P2, B_E0, 2 * LIMB_W);
      STEP_W'(9):  s.issue = mac(DST_ACC, A_P3, B_E0, 3 * LIMB_W);
      STEP_W'(10): s.issue = mac(DST_ACC, A_P0, B_E1, LIMB_W);
      STEP_W'(11): s.issue = mac(DST_ACC, A_P1, B_E1, 2 * LIMB_W);
      STEP_W'(12): s.issue = mac(DST_ACC, A_P2, B_E1, 3 * LIMB_W);
      STEP_W'(13): s.issue = mac(DST_ACC, A_P3, B_E1, 4 * LIMB_W);
      STEP_W'(14): s.issue = mac(DST_ACC_CROSS, A_S0, B_K0, CROSS_SHIFT);
      STEP_W'(15): s.issue = mac(DST_ACC_CROSS, A_S0, B_K1, LIMB_W + CROSS_SHIFT);
      STEP_W'(16): s.issue = mac(DST_ACC_CROSS, A_S1, B_K0, LIMB_W + CROSS_SHIFT);
      STEP_W'(17): s.issue = mac(DST_ACC_CROSS, A_S1, B_K1,
                                 2 * LIMB_W + CROSS_SHIFT);
      default: ;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/hesr_if.sv
// Valid/ready channel interfaces for input items and results.
interface hesr_item_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [hesr_pkg::ITEM_W-1:0]  entity_value;
  logic signed [hesr_pkg::ITEM_W-1:0]  role_weight;
  logic signed [hesr_pkg::ITEM_W-1:0]  normal_value;
  logic signed [hesr_pkg::ITEM_W-1:0]  bias_value;
  logic                                last_role;
  logic                                last_element;

  modport source(output valid, output operation, output entity_value, output role_weight,
                 output normal_value, output bias_value, output last_role,
                 output last_element, input ready);
  modport sink(input valid, input operation, input entity_value, input role_weight,
               input normal_value, input bias_value, input last_role,
               input last_element, output ready);
endinterface

interface hesr_result_if;
  logic                                valid;
  logic                                ready;
  logic [hesr_pkg::SCORE_W-1:0]        score;
  logic [hesr_pkg::RANK_W-1:0]         rank;
  logic                                from_candidate;

  modport source(output valid, output score, output rank, output from_candidate,
                 input ready);
  modport sink(input valid, input score, input rank, input from_candidate,
               output ready);
endinterface

>>> rtl/core/hesr_mul.sv
// Shared signed multiplier with a registered product and destination tag.
module hesr_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hesr_pkg::issue_t                      issue,
  input  logic signed [hesr_pkg::OPND_W-1:0]    opnd_a,
  input  logic signed [hesr_pkg::OPND_W-1:0]    opnd_b,
  output logic signed [hesr_pkg::PROD_W-1:0]    prod,
  output hesr_pkg::tag_t                        tag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.dest  <= hesr_pkg::DST_NONE;
      tag.shift <= '0;
    end else begin
      tag.dest  <= issue.dest;
      tag.shift <= issue.shift;
    end
  end

  always_ff @(posedge clk) begin
    prod <= opnd_a * opnd_b;
  end

endmodule

>>> rtl/core/hesr_ctrl.sv
// Sequencer that steps the shared multiplier through each item and tuple end.
`include "hyperplane_embedding_score_rank_top_defines.svh"

module hesr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_last_role,
  input  logic             item_last_element,
  input  logic             out_free,
  output logic             item_ready,
  output hesr_pkg::ctrl_t  ctrl
);

  hesr_pkg::state_t              state;
  hesr_pkg::state_t              state_next;
  logic [hesr_pkg::STEP_W-1:0]   step;
  logic [hesr_pkg::STEP_W-1:0]   step_next;
  logic                          close_dim;
  logic                          close_tuple;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hesr_pkg::S_IDLE;
      step        <= '0;
      close_dim   <= 1'b0;
      close_tuple <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (ctrl.capture) begin
        // The last item of a tuple also closes the open dimension.
        close_dim   <= item_last_role | item_last_element;
        close_tuple <= item_last_element;
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      hesr_pkg::S_IDLE:   if (item_valid) state_next = hesr_pkg::S_AX;
      hesr_pkg::S_AX:     state_next = close_dim ? hesr_pkg::S_NN : hesr_pkg::S_IDLE;
      hesr_pkg::S_NN:     state_next = hesr_pkg::S_NW;
      hesr_pkg::S_NW:     state_next = hesr_pkg::S_VV;
      hesr_pkg::S_VV:     state_next = hesr_pkg::S_NV;
      hesr_pkg::S_NV:     state_next = close_tuple ? hesr_pkg::S_TDRAIN : hesr_pkg::S_IDLE;
      hesr_pkg::S_TDRAIN: state_next = hesr_pkg::S_TMAG;
      hesr_pkg::S_TMAG: begin
        state_next = hesr_pkg::S_TMAC;
        step_next  = '0;
      end
      hesr_pkg::S_TMAC: begin
        if (step == hesr_pkg::STEP_W'(hesr_pkg::TMAC_LAST)) begin
          state_next = hesr_pkg::S_FIN;
        end else begin
          step_next = step + hesr_pkg::STEP_W'(1);
        end
      end
      hesr_pkg::S_FIN:    if (out_free) state_next = hesr_pkg::S_IDLE;
      default:            state_next = hesr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    hesr_pkg::step_t tstep;
    tstep      = hesr_pkg::tuple_step(step);
    ctrl       = '0;
    ctrl.issue = hesr_pkg::mac(hesr_pkg::DST_NONE, hesr_pkg::A_S0, hesr_pkg::B_S0, 0);
    item_ready = 1'b0;
    case (state)
      hesr_pkg::S_IDLE: begin
        item_ready   = 1'b1;
        ctrl.capture = item_valid;
      end
      hesr_pkg::S_AX:
        ctrl.issue = hesr_pkg::mac(hesr_pkg::DST_WSUM, hesr_pkg::A_ENTITY,
                                   hesr_pkg::B_WEIGHT, 0);
      hesr_pkg::S_NN:
        ctrl.issue = hesr_pkg::mac(hesr_pkg::DST_NENERGY, hesr_pkg::A_NORMAL,
                                   hesr_pkg::B_NORMAL, 0);
      hesr_pkg::S_NW: begin
        // The weighted sum is complete here; it feeds the dot product and vsum and is cleared.
        ctrl.issue      = hesr_pkg::mac(hesr_pkg::DST_NDOT, hesr_pkg::A_NORMAL,
                                        hesr_pkg::B_WSUM, 0);
        ctrl.load_v     = 1'b1;
        ctrl.clear_wsum = 1'b1;
      end
      hesr_pkg::S_VV:
        ctrl.issue = hesr_pkg::mac(hesr_pkg::DST_SQ, hesr_pkg::A_VSUM,
                                   hesr_pkg::B_VSUM, 0);
      hesr_pkg::S_NV:
        ctrl.issue = hesr_pkg::mac(hesr_pkg::DST_NCROSS, hesr_pkg::A_NORMAL,
                                   hesr_pkg::B_VSUM, 0);
      hesr_pkg::S_TMAG:   ctrl.load_mag = 1'b1;
      hesr_pkg::S_TMAC: begin
        ctrl.issue   = tstep.issue;
        ctrl.latch_p = tstep.latch_p;
      end
      hesr_pkg::S_FIN:    ctrl.finish = out_free;
      default: ;
    endcase
  end

  `HESR_ASSERT_IMPL(a_finish_needs_room, clk, rst, ctrl.finish, out_free, "result written while output register is full")
  `HESR_ASSERT_NEXT(a_accept_starts_item, clk, rst, item_valid && item_ready, state == hesr_pkg::S_AX, "accepted item did not start its multiply")
  `HESR_ASSERT_IMPL(a_no_issue_when_ready, clk, rst, item_ready, ctrl.issue.dest == hesr_pkg::DST_NONE && !ctrl.finish, "work issued while taking a new item")

endmodule

>>> rtl/core/hesr_datapath.sv
// Item registers, running sums, wide accumulator, score and rank logic.
`include "hyperplane_embedding_score_rank_top_defines.svh"

module hesr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hesr_pkg::ctrl_t                       ctrl,
  input  logic                                  operation,
  input  logic signed [hesr_pkg::ITEM_W-1:0]    entity_value,
  input  logic signed [hesr_pkg::ITEM_W-1:0]    role_weight,
  input  logic signed [hesr_pkg::ITEM_W-1:0]    normal_value,
  input  logic signed [hesr_pkg::ITEM_W-1:0]    bias_value,
  input  logic signed [hesr_pkg::PROD_W-1:0]    prod,
  input  hesr_pkg::tag_t                        tag,
  output logic signed [hesr_pkg::OPND_W-1:0]    opnd_a,
  output logic signed [hesr_pkg::OPND_W-1:0]    opnd_b,
  input  logic                                  result_ready,
  output logic                                  result_valid,
  output logic [hesr_pkg::SCORE_W-1:0]          result_score,
  output logic [hesr_pkg::RANK_W-1:0]           result_rank,
  output logic                                  result_from_candidate,
  output logic                                  out_free
);

  localparam int ACC_W  = hesr_pkg::ACC_W;
  localparam int LIMB_W = hesr_pkg::LIMB_W;

  logic signed [hesr_pkg::ITEM_W-1:0]  entity_r;
  logic signed [hesr_pkg::ITEM_W-1:0]  weight_r;
  logic signed [hesr_pkg::ITEM_W-1:0]  normal_r;
  logic signed [hesr_pkg::ITEM_W-1:0]  bias_r;
  logic                                op_r;

  logic [hesr_pkg::WSUM_W-1:0]   weighted_sum;
  logic [hesr_pkg::SQ_W-1:0]     square_sum;
  logic [hesr_pkg::NDOT_W-1:0]   normal_dot_sum;
  logic [hesr_pkg::NDOT_W-1:0]   normal_cross_sum;
  logic [hesr_pkg::NEN_W-1:0]    normal_energy;
  logic [hesr_pkg::SCORE_W-1:0]  reference_score;
  logic [hesr_pkg::RANK_W-1:0]   rank_count;

  logic signed [hesr_pkg::VSUM_W-1:0]  vsum;
  logic [hesr_pkg::MAG_W-1:0]          s_mag;
  logic [hesr_pkg::MAG_W-1:0]          k_mag;
  logic [hesr_pkg::MAG_W-1:0]          s_mag_next;
  logic [hesr_pkg::MAG_W-1:0]          k_mag_next;
  logic                                cross_add;
  logic [hesr_pkg::P_W-1:0]            p_reg;
  logic [ACC_W-1:0]                    acc;
  logic [ACC_W-1:0]                    prod_ext;
  logic [ACC_W-1:0]                    term;
  logic [hesr_pkg::SCORE_W-1:0]        fin_score;
  logic [hesr_pkg::RANK_W-1:0]         rank_next;

  assign prod_ext = {{(ACC_W - hesr_pkg::PROD_W){prod[hesr_pkg::PROD_W-1]}}, prod};
  assign term     = prod_ext << tag.shift;

  assign s_mag_next = normal_dot_sum[hesr_pkg::NDOT_W-1] ?
                      (~normal_dot_sum + hesr_pkg::NDOT_W'(1)) : normal_dot_sum;
  assign k_mag_next = normal_cross_sum[hesr_pkg::NDOT_W-1] ?
                      (~normal_cross_sum + hesr_pkg::NDOT_W'(1)) : normal_cross_sum;

  always_comb begin
    case (ctrl.issue.a_sel)
      hesr_pkg::A_ENTITY: opnd_a = hesr_pkg::OPND_W'(entity_r);
      hesr_pkg::A_NORMAL: opnd_a = hesr_pkg::OPND_W'(normal_r);
      hesr_pkg::A_VSUM:   opnd_a = hesr_pkg::OPND_W'(vsum);
      hesr_pkg::A_S0:     opnd_a = hesr_pkg::OPND_W'(s_mag[LIMB_W-1:0]);
      hesr_pkg::A_S1:     opnd_a = hesr_pkg::OPND_W'(s_mag[hesr_pkg::MAG_W-1:LIMB_W]);
      hesr_pkg::A_P0:     opnd_a = hesr_pkg::OPND_W'(p_reg[LIMB_W-1:0]);
      hesr_pkg::A_P1:     opnd_a = hesr_pkg::OPND_W'(p_reg[2*LIMB_W-1:LIMB_W]);
      hesr_pkg::A_P2:     opnd_a = hesr_pkg::OPND_W'(p_reg[3*LIMB_W-1:2*LIMB_W]);
      hesr_pkg::A_P3:     opnd_a = hesr_pkg::OPND_W'(p_reg[hesr_pkg::P_W-1:3*LIMB_W]);
      default:            opnd_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.issue.b_sel)
      hesr_pkg::B_WEIGHT: opnd_b = hesr_pkg::OPND_W'(weight_r);
      hesr_pkg::B_NORMAL: opnd_b = hesr_pkg::OPND_W'(normal_r);
      hesr_pkg::B_WSUM:   opnd_b = hesr_pkg::OPND_W'(signed'(weighted_sum));
      hesr_pkg::B_VSUM:   opnd_b = hesr_pkg::OPND_W'(vsum);
      hesr_pkg::B_S0:     opnd_b = hesr_pkg::OPND_W'(s_mag[LIMB_W-1:0]);
      hesr_pkg::B_S1:     opnd_b = hesr_pkg::OPND_W'(s_mag[hesr_pkg::MAG_W-1:LIMB_W]);
      hesr_pkg::B_K0:     opnd_b = hesr_pkg::OPND_W'(k_mag[LIMB_W-1:0]);
      hesr_pkg::B_K1:     opnd_b = hesr_pkg::OPND_W'(k_mag[hesr_pkg::MAG_W-1:LIMB_W]);
      hesr_pkg::B_E0:     opnd_b = hesr_pkg::OPND_W'(normal_energy[LIMB_W-1:0]);
      hesr_pkg::B_E1:     opnd_b = hesr_pkg::OPND_W'(normal_energy[hesr_pkg::NEN_W-1:LIMB_W]);
      default:            opnd_b = '0;
    endcase
  end

  // A negative total floors to zero; anything at or above 2^48 saturates.
  always_comb begin
    if (acc[ACC_W-1]) begin
      fin_score = '0;
    end else if (|acc[ACC_W-2:hesr_pkg::SCORE_LSB+hesr_pkg::SCORE_W]) begin
      fin_score = hesr_pkg::SCORE_SAT;
    end else begin
      fin_score = acc[hesr_pkg::SCORE_LSB+hesr_pkg::SCORE_W-1:hesr_pkg::SCORE_LSB];
    end
  end

  always_comb begin
    if (!op_r) begin
      rank_next = hesr_pkg::RANK_ONE;
    end else if (fin_score <= reference_score && rank_count < hesr_pkg::RANK_MAX) begin
      rank_next = rank_count + hesr_pkg::RANK_W'(1);
    end else begin
      rank_next = rank_count;
    end
  end

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_sum     <= '0;
      square_sum       <= '0;
      normal_dot_sum   <= '0;
      normal_cross_sum <= '0;
      normal_energy    <= '0;
      reference_score  <= '0;
      rank_count       <= hesr_pkg::RANK_ONE;
      result_valid     <= 1'b0;
    end else begin
      if (ctrl.clear_wsum) begin
        weighted_sum <= '0;
      end else if (tag.dest == hesr_pkg::DST_WSUM) begin
        weighted_sum <= weighted_sum + prod[hesr_pkg::WSUM_W-1:0];
      end
      if (ctrl.finish) begin
        square_sum       <= '0;
        normal_dot_sum   <= '0;
        normal_cross_sum <= '0;
        normal_energy    <= '0;
        rank_count       <= rank_next;
        if (!op_r) begin
          reference_score <= fin_score;
        end
      end else begin
        if (tag.dest == hesr_pkg::DST_SQ) begin
          square_sum <= square_sum + prod[hesr_pkg::SQ_W-1:0];
        end
        if (tag.dest == hesr_pkg::DST_NDOT) begin
          normal_dot_sum <= normal_dot_sum + prod[hesr_pkg::NDOT_W-1:0];
        end
        if (tag.dest == hesr_pkg::DST_NCROSS) begin
          normal_cross_sum <= normal_cross_sum + prod[hesr_pkg::NDOT_W-1:0];
        end
        if (tag.dest == hesr_pkg::DST_NENERGY) begin
          normal_energy <= normal_energy + prod[hesr_pkg::NEN_W-1:0];
        end
      end
      if (ctrl.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      entity_r <= entity_value;
      weight_r <= role_weight;
      normal_r <= normal_value;
      bias_r   <= bias_value;
      op_r     <= operation;
    end
    if (ctrl.load_v) begin
      vsum <= hesr_pkg::VSUM_W'(signed'(weighted_sum)) +
              (hesr_pkg::VSUM_W'(bias_r) <<< hesr_pkg::BIAS_SHIFT);
    end
    if (ctrl.load_mag) begin
      s_mag     <= s_mag_next;
      k_mag     <= k_mag_next;
      cross_add <= normal_dot_sum[hesr_pkg::NDOT_W-1] ^ normal_cross_sum[hesr_pkg::NDOT_W-1];
    end
    if (ctrl.latch_p) begin
      p_reg <= acc[hesr_pkg::P_W-1:0];
    end
    if (ctrl.load_mag) begin
      acc <= '0;
    end else if (ctrl.latch_p) begin
      acc <= {{(ACC_W - hesr_pkg::SQ_W - hesr_pkg::Q_SHIFT){1'b0}}, square_sum,
              {hesr_pkg::Q_SHIFT{1'b0}}};
    end else if (tag.dest == hesr_pkg::DST_ACC) begin
      acc <= acc + term;
    end else if (tag.dest == hesr_pkg::DST_ACC_CROSS) begin
      // The cross term is subtracted when s and k share a sign.
      acc <= cross_add ? (acc + term) : (acc - term);
    end
    if (ctrl.finish) begin
      result_score          <= fin_score;
      result_rank           <= rank_next;
      result_from_candidate <= op_r;
    end
  end

  `HESR_ASSERT_NEXT(a_sums_cleared, clk, rst, ctrl.finish, square_sum == '0 && normal_energy == '0 && normal_dot_sum == '0 && normal_cross_sum == '0, "tuple sums not cleared after result")
  `HESR_ASSERT_IMPL(a_rank_range, clk, rst, 1'b1, rank_count != '0 && rank_count <= hesr_pkg::RANK_MAX, "rank count out of range")

endmodule

>>> rtl/core/hyperplane_embedding_score_rank_top.sv
// Top level of the hyperplane tuple embedding scorer with ranking.
//
// Items enter on the item channel, one per (dimension, role), and are taken
// when valid and ready are both high. A tuple's last item produces one beat
// on the result channel: the floored and saturated Q32.16 score, the rank and
// whether the tuple was a candidate; other items produce no beat.
// All arithmetic runs on one shared 29x29 signed multiplier, registered,
// driven by a small sequencer, so ready is low while an item is in work.
// An item that does not close a dimension issues only the weighted product; one
// that closes a dimension adds four dimension products. After the dimension
// products of a tuple's last item, 19 steps of the multiplier build the 128-bit
// total limb by limb; the result beat is then registered from the final step,
// which waits while the output register is still full.
// Synchronous reset clears all running sums and the reference score and sets
// rank to 1; no clearing pass is needed. The result sits in an output register,
// so new items are taken while a beat waits; if a second tuple finishes before
// the earlier beat is taken, the block holds in its final step until it is.
module hyperplane_embedding_score_rank_top (
  input  logic             clk,
  input  logic             rst,
  hesr_item_if.sink        item,
  hesr_result_if.source    result
);

  hesr_pkg::ctrl_t                      ctrl;
  hesr_pkg::tag_t                       tag;
  logic signed [hesr_pkg::OPND_W-1:0]   opnd_a;
  logic signed [hesr_pkg::OPND_W-1:0]   opnd_b;
  logic signed [hesr_pkg::PROD_W-1:0]   prod;
  logic                                 out_free;

  hesr_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item.valid),
    .item_last_role    (item.last_role),
    .item_last_element (item.last_element),
    .out_free          (out_free),
    .item_ready        (item.ready),
    .ctrl              (ctrl)
  );

  hesr_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .issue  (ctrl.issue),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .prod   (prod),
    .tag    (tag)
  );

  hesr_datapath u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .ctrl                  (ctrl),
    .operation             (item.operation),
    .entity_value          (item.entity_value),
    .role_weight           (item.role_weight),
    .normal_value          (item.normal_value),
    .bias_value            (item.bias_value),
    .prod                  (prod),
    .tag                   (tag),
    .opnd_a                (opnd_a),
    .opnd_b                (opnd_b),
    .result_ready          (result.ready),
    .result_valid          (result.valid),
    .result_score          (result.score),
    .result_rank           (result.rank),
    .result_from_candidate (result.from_candidate),
    .out_free              (out_free)
  );

endmodule
